### rtl/core/gpg_pkg.sv
// Shared types, constants and the 5x8 glyph ROM for the glyph pixel generator.
// No dependencies; used by the front, queue, back and top-level modules of the block.
`timescale 1ns / 1ps

package gpg_pkg;

    // Panel geometry used by the 90 degree rotation
    localparam logic [7:0] PANEL_WIDTH = 8'd175;

    // Drawable code range and lower-case fold point
    localparam logic [7:0] CODE_FIRST = 8'h20;
    localparam logic [7:0] CODE_LAST  = 8'h7F;
    localparam logic [7:0] FOLD_FROM  = 8'h61;
    localparam logic [7:0] FOLD_DELTA = 8'h20;

    // Glyph shape
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
    localparam int GLYPH_IDX_W = 7;
    localparam int COL_W       = 3;
    localparam int ROW_W       = 3;
    localparam logic [COL_W-1:0] COL_LAST = 3'(GLYPH_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = 3'(GLYPH_ROWS - 1);

    // Request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One classified draw request
    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph;   // bit (col*8 + row)
        logic [7:0]            origin_x;
        logic [7:0]            origin_y;
        logic [15:0]           fg_color;
        logic [15:0]           bg_color;
    } gpg_req_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } gpg_q_stat_t;

    // Glyph bitmap, column 0 in the low byte; space through backtick
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
        logic [GLYPH_BITS-1:0] g;
        case (idx)
            7'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            7'd1:  g = {8'h00, 8'h00, 8'h2F, 8'h00, 8'h00};
            7'd2:  g = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
            7'd3:  g = {8'h14, 8'h3E, 8'h14, 8'h3E, 8'h14};
            7'd4:  g = {8'h10, 8'h2A, 8'h3E, 8'h2A, 8'h04};
            7'd5:  g = {8'h00, 8'h32, 8'h04, 8'h08, 8'h13};
            7'd6:  g = {8'h00, 8'h20, 8'h14, 8'h2A, 8'h14};
            7'd7:  g = {8'h00, 8'h00, 8'h07, 8'h00, 8'h00};
            7'd8:  g = {8'h00, 8'h00, 8'h21, 8'h1E, 8'h00};
            7'd9:  g = {8'h00, 8'h00, 8'h1E, 8'h21, 8'h00};
            7'd10: g = {8'h00, 8'h2A, 8'h1C, 8'h2A, 8'h00};
            7'd11: g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
            7'd12: g = {8'h00, 8'h10, 8'h30, 8'h40, 8'h00};
            7'd13: g = {8'h00, 8'h08, 8'h08, 8'h08, 8'h08};
            7'd14: g = {8'h00, 8'h00, 8'h30, 8'h30, 8'h00};
            7'd15: g = {8'h00, 8'h02, 8'h04, 8'h08, 8'h10};
            7'd16: g = {8'h00, 8'h1E, 8'h21, 8'h1E, 8'h00};
            7'd17: g = {8'h00, 8'h20, 8'h3F, 8'h22, 8'h00};
            7'd18: g = {8'h00, 8'h26, 8'h29, 8'h31, 8'h22};
            7'd19: g = {8'h00, 8'h1B, 8'h25, 8'h25, 8'h11};
            7'd20: g = {8'h00, 8'h08, 8'h3F, 8'h0A, 8'h0C};
            7'd21: g = {8'h00, 8'h19, 8'h25, 8'h25, 8'h17};
            7'd22: g = {8'h00, 8'h18, 8'h25, 8'h25, 8'h1E};
            7'd23: g = {8'h00, 8'h03, 8'h0D, 8'h31, 8'h01};
            7'd24: g = {8'h00, 8'h1A, 8'h25, 8'h25, 8'h1A};
            7'd25: g = {8'h00, 8'h1E, 8'h29, 8'h29, 8'h06};
            7'd26: g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
            7'd27: g = {8'h00, 8'h00, 8'h16, 8'h36, 8'h40};
            7'd28: g = {8'h00, 8'h22, 8'h14, 8'h08, 8'h00};
            7'd29: g = {8'h00, 8'h14, 8'h14, 8'h14, 8'h14};
            7'd30: g = {8'h00, 8'h08, 8'h14, 8'h22, 8'h00};
            7'd31: g = {8'h00, 8'h06, 8'h29, 8'h02, 8'h00};
            7'd32: g = {8'h00, 8'h0E, 8'h2D, 8'h21, 8'h1E};
            7'd33: g = {8'h00, 8'h3E, 8'h09, 8'h09, 8'h3E};
            7'd34: g = {8'h00, 8'h1A, 8'h25, 8'h25, 8'h3F};
            7'd35: g = {8'h00, 8'h12, 8'h21, 8'h21, 8'h1E};
            7'd36: g = {8'h00, 8'h1E, 8'h21, 8'h21, 8'h3F};
            7'd37: g = {8'h00, 8'h21, 8'h25, 8'h25, 8'h3F};
            7'd38: g = {8'h00, 8'h01, 8'h05, 8'h05, 8'h3F};
            7'd39: g = {8'h00, 8'h3A, 8'h29, 8'h21, 8'h1E};
            7'd40: g = {8'h00, 8'h3F, 8'h04, 8'h04, 8'h3F};
            7'd41: g = {8'h00, 8'h21, 8'h3F, 8'h21, 8'h00};
            7'd42: g = {8'h00, 8'h1F, 8'h20, 8'h20, 8'h10};
            7'd43: g = {8'h00, 8'h21, 8'h12, 8'h0C, 8'h3F};
            7'd44: g = {8'h00, 8'h20, 8'h20, 8'h20, 8'h3F};
            7'd45: g = {8'h00, 8'h3F, 8'h06, 8'h06, 8'h3F};
            7'd46: g = {8'h00, 8'h3F, 8'h18, 8'h06, 8'h3F};
            7'd47: g = {8'h00, 8'h1E, 8'h21, 8'h21, 8'h1E};
            7'd48: g = {8'h00, 8'h06, 8'h09, 8'h09, 8'h3F};
            7'd49: g = {8'h00, 8'h5E, 8'h21, 8'h31, 8'h1E};
            7'd50: g = {8'h00, 8'h26, 8'h19, 8'h09, 8'h3F};
            7'd51: g = {8'h00, 8'h12, 8'h29, 8'h25, 8'h12};
            7'd52: g = {8'h00, 8'h01, 8'h3F, 8'h01, 8'h00};
            7'd53: g = {8'h00, 8'h1F, 8'h20, 8'h20, 8'h1F};
            7'd54: g = {8'h00, 8'h0F, 8'h30, 8'h30, 8'h0F};
            7'd55: g = {8'h00, 8'h3F, 8'h18, 8'h18, 8'h3F};
            7'd56: g = {8'h00, 8'h33, 8'h0C, 8'h0C, 8'h33};
            7'd57: g = {8'h00, 8'h07, 8'h38, 8'h07, 8'h00};
            7'd58: g = {8'h00, 8'h23, 8'h25, 8'h29, 8'h31};
            7'd59: g = {8'h00, 8'h21, 8'h21, 8'h3F, 8'h00};
            7'd60: g = {8'h00, 8'h10, 8'h08, 8'h04, 8'h02};
            7'd61: g = {8'h00, 8'h3F, 8'h21, 8'h21, 8'h00};
            7'd62: g = {8'h00, 8'h02, 8'h01, 8'h02, 8'h00};
            7'd63: g = {8'h00, 8'h20, 8'h20, 8'h20, 8'h20};
            // backtick, also serves any index past the end
            default: g = {8'h00, 8'h00, 8'h02, 8'h01, 8'h00};
        endcase
        return g;
    endfunction

endpackage

### rtl/core/gpg_front.sv
// Front end: accepts draw requests, drops undrawable codes, folds lower case
// and looks up the glyph bitmap. Depends on gpg_pkg.
`timescale 1ns / 1ps

module gpg_front (
    input  logic              push,
    output logic              full,
    input  logic [7:0]        char_code,
    input  logic [7:0]        origin_x,
    input  logic [7:0]        origin_y,
    input  logic [15:0]       fg_color,
    input  logic [15:0]       bg_color,
    input  gpg_pkg::gpg_q_stat_t q_stat,
    output logic              q_push,
    output gpg_pkg::gpg_req_t q_req
);
    import gpg_pkg::*;

    logic                   drawable;
    logic [7:0]             folded;
    logic [7:0]             idx_full;
    logic [GLYPH_IDX_W-1:0] idx;

    // Classify the code
    always_comb
    begin
        drawable = (char_code inside {[CODE_FIRST:CODE_LAST]});
        folded   = (char_code >= FOLD_FROM) ? (char_code - FOLD_DELTA) : char_code;
        idx_full = folded - CODE_FIRST;
        idx      = idx_full[GLYPH_IDX_W-1:0];
    end

    // Build the request; undrawable codes are accepted and dropped
    assign full   = q_stat.full;
    assign q_push = push && !q_stat.full && drawable;

    always_comb
    begin
        q_req.glyph    = glyph_bits(idx);
        q_req.origin_x = origin_x;
        q_req.origin_y = origin_y;
        q_req.fg_color = fg_color;
        q_req.bg_color = bg_color;
    end

endmodule

### rtl/core/gpg_queue.sv
// Short request queue between the front and the back end.
// Depends on gpg_pkg for the entry type and depth.
`timescale 1ns / 1ps

module gpg_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_push,
    input  gpg_pkg::gpg_req_t    q_req,
    input  logic                 q_pop,
    output gpg_pkg::gpg_q_stat_t q_stat,
    output gpg_pkg::gpg_req_t    q_head
);
    import gpg_pkg::*;

    gpg_req_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_head       = entry_reg[rd_ptr_reg];

    assign do_push = q_push && !q_stat.full;
    assign do_pop  = q_pop && !q_stat.empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_req;
        end
    end

endmodule

### rtl/core/gpg_back.sv
// Back end: walks the 40 pixels of a glyph, column by column and row by row,
// rotates coordinates and holds each pixel in an output register. Depends on gpg_pkg.
`timescale 1ns / 1ps

module gpg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gpg_pkg::gpg_q_stat_t q_stat,
    input  gpg_pkg::gpg_req_t    q_head,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           ram_x,
    output logic [7:0]           ram_y,
    output logic [7:0]           win_x_end,
    output logic [7:0]           win_y_end,
    output logic [15:0]          pixel_color,
    output logic                 last_pixel
);
    import gpg_pkg::*;

    gpg_req_t         cur_reg;
    logic             busy_reg, busy_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]  ram_x_reg, ram_y_reg, win_x_end_reg, win_y_end_reg;
    logic [15:0] pixel_color_reg;
    logic        last_pixel_reg;

    logic        advance, is_last, load;
    logic [7:0]  px, px1, py, rot_a, rot_b;
    logic        bit_set;
    logic [5:0]  bit_idx;

    // Handshake: step when the output register is free or being drained
    assign advance = busy_reg && (!out_valid_reg || pop);
    assign is_last = (col_reg == COL_LAST) && (row_reg == ROW_LAST);
    assign load    = !q_stat.empty && (!busy_reg || (advance && is_last));
    assign q_pop   = load;

    // Pixel coordinates and color
    always_comb
    begin
        px      = cur_reg.origin_x + 8'(col_reg);
        px1     = px + 8'd1;
        py      = cur_reg.origin_y + 8'(row_reg);
        rot_a   = PANEL_WIDTH - py - 8'd1;
        rot_b   = rot_a - 8'd1;
        bit_idx = {col_reg, row_reg};
        bit_set = cur_reg.glyph[bit_idx];
    end

    // Sequencer next state
    always_comb
    begin
        busy_next      = busy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            col_next  = '0;
            row_next  = '0;
        end
        else if (advance)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else if (row_reg == ROW_LAST)
            begin
                row_next = '0;
                col_next = col_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Current request and output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_head;
        end
        if (advance)
        begin
            ram_x_reg       <= (rot_a < rot_b) ? rot_a : rot_b;
            win_x_end_reg   <= (rot_a < rot_b) ? rot_b : rot_a;
            ram_y_reg       <= (px < px1) ? px : px1;
            win_y_end_reg   <= (px < px1) ? px1 : px;
            pixel_color_reg <= bit_set ? cur_reg.fg_color : cur_reg.bg_color;
            last_pixel_reg  <= is_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign ram_x       = ram_x_reg;
    assign ram_y       = ram_y_reg;
    assign win_x_end   = win_x_end_reg;
    assign win_y_end   = win_y_end_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule

### rtl/core/glyph_pixel_generator_unit.sv
// A drawable request moves from a queue entry into the current-request register of the
// sequencer, and its first pixel into the output register. Throughput: one pixel per
// cycle from the back-end pixel sequencer while the receiver pops; undrawable codes are taken and give nothing.
// The two-entry request queue accepts new requests while a glyph is being drawn.
// Reset (rst_n low, asynchronous) empties the queue, idles the sequencer and the output.
// Top level: instantiates gpg_front, gpg_queue and gpg_back; depends on gpg_pkg.
`timescale 1ns / 1ps

module glyph_pixel_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    input  logic [7:0]  origin_x,
    input  logic [7:0]  origin_y,
    input  logic [15:0] fg_color,
    input  logic [15:0] bg_color,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  ram_x,
    output logic [7:0]  ram_y,
    output logic [7:0]  win_x_end,
    output logic [7:0]  win_y_end,
    output logic [15:0] pixel_color,
    output logic        last_pixel
);
    import gpg_pkg::*;

    gpg_q_stat_t q_stat;
    gpg_req_t    q_req;
    gpg_req_t    q_head;
    logic        q_push;
    logic        q_pop;

    // Request classification
    gpg_front u_front (
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .fg_color  (fg_color),
        .bg_color  (bg_color),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_req     (q_req)
    );

    // Decoupling queue
    gpg_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_req  (q_req),
        .q_pop  (q_pop),
        .q_stat (q_stat),
        .q_head (q_head)
    );

    // Pixel generation
    gpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .ram_x       (ram_x),
        .ram_y       (ram_y),
        .win_x_end   (win_x_end),
        .win_y_end   (win_y_end),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

### rtl/core/gpg_checker.sv
// Port-level checks for the glyph pixel generator, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module gpg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  ram_x,
    input logic [7:0]  ram_y,
    input logic [7:0]  win_x_end,
    input logic [7:0]  win_y_end,
    input logic [15:0] pixel_color,
    input logic        last_pixel
);

    // A waiting pixel stays until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("pixel dropped while not popped");

    // A waiting pixel holds its color, ram_x and last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(pixel_color) && $stable(ram_x) && $stable(last_pixel))
        else $error("pixel payload changed while stalled");

    // Window rows span x and x+1 with 8-bit wrap
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (win_y_end == ram_y + 8'd1) || (ram_y == 8'd0 && win_y_end == 8'hFF))
        else $error("row window is not two adjacent rows");

    // Window columns are the two adjacent rotated columns
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (win_x_end == ram_x + 8'd1) || (ram_x == 8'd0 && win_x_end == 8'hFF))
        else $error("column window is not two adjacent columns");

endmodule

bind glyph_pixel_generator_unit gpg_checker u_gpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .ram_x       (ram_x),
    .ram_y       (ram_y),
    .win_x_end   (win_x_end),
    .win_y_end   (win_y_end),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
);

### sim/tb_glyph_pixel_generator_unit.sv
// Self-checking bench for glyph_pixel_generator_unit: random and directed draw requests,
// a pixel predictor with its own 5x8 font table, random stalls on both queue sides.
// Depends on gpg_pkg (code range, fold point, glyph shape and panel width) and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_glyph_pixel_generator_unit;
    import gpg_pkg::*;

    // One draw request as queued for the driver
    typedef struct packed {
        logic [7:0]  code;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [4:0]  gap;      // idle cycles before the request is offered
        logic        drain;    // wait for every pending pixel before offering
    } draw_req_t;

    // One predicted pixel write
    typedef struct packed {
        logic [7:0]  ram_x;
        logic [7:0]  ram_y;
        logic [7:0]  win_x_end;
        logic [7:0]  win_y_end;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  char_code = 8'h00;
    logic [7:0]  origin_x = 8'h00;
    logic [7:0]  origin_y = 8'h00;
    logic [15:0] fg_color = 16'h0000;
    logic [15:0] bg_color = 16'h0000;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  ram_x;
    logic [7:0]  ram_y;
    logic [7:0]  win_x_end;
    logic [7:0]  win_y_end;
    logic [15:0] pixel_color;
    logic        last_pixel;

    draw_req_t   req_q[$];
    pixel_t      pixels_due[$];
    draw_req_t   staged_req;
    bit          staged = 1'b0;
    int          requests_taken = 0;
    int          errors = 0;
    int          pixels_seen = 0;
    int          rx_wait = 0;
    bit          rx_calm = 1'b0;
    logic        hold_long = 1'b0;

    glyph_pixel_generator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_code   (char_code),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .fg_color    (fg_color),
        .bg_color    (bg_color),
        .empty       (empty),
        .pop         (pop),
        .ram_x       (ram_x),
        .ram_y       (ram_y),
        .win_x_end   (win_x_end),
        .win_y_end   (win_y_end),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Font table, column 0 in the top byte; space through backtick
    function automatic logic [39:0] font_columns(input logic [6:0] idx);
        logic [39:0] f;
        case (idx)
            7'd0:  f = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            7'd1:  f = {8'h00, 8'h00, 8'h2F, 8'h00, 8'h00};
            7'd2:  f = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
            7'd3:  f = {8'h14, 8'h3E, 8'h14, 8'h3E, 8'h14};
            7'd4:  f = {8'h04, 8'h2A, 8'h3E, 8'h2A, 8'h10};
            7'd5:  f = {8'h13, 8'h08, 8'h04, 8'h32, 8'h00};
            7'd6:  f = {8'h14, 8'h2A, 8'h14, 8'h20, 8'h00};
            7'd7:  f = {8'h00, 8'h00, 8'h07, 8'h00, 8'h00};
            7'd8:  f = {8'h00, 8'h1E, 8'h21, 8'h00, 8'h00};
            7'd9:  f = {8'h00, 8'h21, 8'h1E, 8'h00, 8'h00};
            7'd10: f = {8'h00, 8'h2A, 8'h1C, 8'h2A, 8'h00};
            7'd11: f = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
            7'd12: f = {8'h00, 8'h40, 8'h30, 8'h10, 8'h00};
            7'd13: f = {8'h08, 8'h08, 8'h08, 8'h08, 8'h00};
            7'd14: f = {8'h00, 8'h30, 8'h30, 8'h00, 8'h00};
            7'd15: f = {8'h10, 8'h08, 8'h04, 8'h02, 8'h00};
            7'd16: f = {8'h00, 8'h1E, 8'h21, 8'h1E, 8'h00};
            7'd17: f = {8'h00, 8'h22, 8'h3F, 8'h20, 8'h00};
            7'd18: f = {8'h22, 8'h31, 8'h29, 8'h26, 8'h00};
            7'd19: f = {8'h11, 8'h25, 8'h25, 8'h1B, 8'h00};
            7'd20: f = {8'h0C, 8'h0A, 8'h3F, 8'h08, 8'h00};
            7'd21: f = {8'h17, 8'h25, 8'h25, 8'h19, 8'h00};
            7'd22: f = {8'h1E, 8'h25, 8'h25, 8'h18, 8'h00};
            7'd23: f = {8'h01, 8'h31, 8'h0D, 8'h03, 8'h00};
            7'd24: f = {8'h1A, 8'h25, 8'h25, 8'h1A, 8'h00};
            7'd25: f = {8'h06, 8'h29, 8'h29, 8'h1E, 8'h00};
            7'd26: f = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            7'd27: f = {8'h40, 8'h36, 8'h16, 8'h00, 8'h00};
            7'd28: f = {8'h00, 8'h08, 8'h14, 8'h22, 8'h00};
            7'd29: f = {8'h14, 8'h14, 8'h14, 8'h14, 8'h00};
            7'd30: f = {8'h00, 8'h22, 8'h14, 8'h08, 8'h00};
            7'd31: f = {8'h00, 8'h02, 8'h29, 8'h06, 8'h00};
            7'd32: f = {8'h1E, 8'h21, 8'h2D, 8'h0E, 8'h00};
            7'd33: f = {8'h3E, 8'h09, 8'h09, 8'h3E, 8'h00};
            7'd34: f = {8'h3F, 8'h25, 8'h25, 8'h1A, 8'h00};
            7'd35: f = {8'h1E, 8'h21, 8'h21, 8'h12, 8'h00};
            7'd36: f = {8'h3F, 8'h21, 8'h21, 8'h1E, 8'h00};
            7'd37: f = {8'h3F, 8'h25, 8'h25, 8'h21, 8'h00};
            7'd38: f = {8'h3F, 8'h05, 8'h05, 8'h01, 8'h00};
            7'd39: f = {8'h1E, 8'h21, 8'h29, 8'h3A, 8'h00};
            7'd40: f = {8'h3F, 8'h04, 8'h04, 8'h3F, 8'h00};
            7'd41: f = {8'h00, 8'h21, 8'h3F, 8'h21, 8'h00};
            7'd42: f = {8'h10, 8'h20, 8'h20, 8'h1F, 8'h00};
            7'd43: f = {8'h3F, 8'h0C, 8'h12, 8'h21, 8'h00};
            7'd44: f = {8'h3F, 8'h20, 8'h20, 8'h20, 8'h00};
            7'd45: f = {8'h3F, 8'h06, 8'h06, 8'h3F, 8'h00};
            7'd46: f = {8'h3F, 8'h06, 8'h18, 8'h3F, 8'h00};
            7'd47: f = {8'h1E, 8'h21, 8'h21, 8'h1E, 8'h00};
            7'd48: f = {8'h3F, 8'h09, 8'h09, 8'h06, 8'h00};
            7'd49: f = {8'h1E, 8'h31, 8'h21, 8'h5E, 8'h00};
            7'd50: f = {8'h3F, 8'h09, 8'h19, 8'h26, 8'h00};
            7'd51: f = {8'h12, 8'h25, 8'h29, 8'h12, 8'h00};
            7'd52: f = {8'h00, 8'h01, 8'h3F, 8'h01, 8'h00};
            7'd53: f = {8'h1F, 8'h20, 8'h20, 8'h1F, 8'h00};
            7'd54: f = {8'h0F, 8'h30, 8'h30, 8'h0F, 8'h00};
            7'd55: f = {8'h3F, 8'h18, 8'h18, 8'h3F, 8'h00};
            7'd56: f = {8'h33, 8'h0C, 8'h0C, 8'h33, 8'h00};
            7'd57: f = {8'h00, 8'h07, 8'h38, 8'h07, 8'h00};
            7'd58: f = {8'h31, 8'h29, 8'h25, 8'h23, 8'h00};
            7'd59: f = {8'h00, 8'h3F, 8'h21, 8'h21, 8'h00};
            7'd60: f = {8'h02, 8'h04, 8'h08, 8'h10, 8'h00};
            7'd61: f = {8'h00, 8'h21, 8'h21, 8'h3F, 8'h00};
            7'd62: f = {8'h00, 8'h02, 8'h01, 8'h02, 8'h00};
            7'd63: f = {8'h20, 8'h20, 8'h20, 8'h20, 8'h00};
            default: f = {8'h00, 8'h01, 8'h02, 8'h00, 8'h00};
        endcase
        return f;
    endfunction

    // Expected pixel writes for one accepted draw request
    task automatic predict_glyph(input logic [7:0] code, input logic [7:0] ox,
                                 input logic [7:0] oy, input logic [15:0] fg,
                                 input logic [15:0] bg);
        logic [7:0]  folded;
        logic [6:0]  idx;
        logic [39:0] cols;
        logic [7:0]  bits;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [7:0]  px1;
        logic [7:0]  py1;
        logic [7:0]  a;
        logic [7:0]  b;
        pixel_t      p;
        if (code >= CODE_FIRST && code <= CODE_LAST)
        begin
            // lower case and up fold onto the upper half of the font
            folded = (code >= FOLD_FROM) ? code - FOLD_DELTA : code;
            idx = 7'(folded - CODE_FIRST);
            cols = font_columns(idx);
            for (int c = 0; c < GLYPH_COLS; c++)
            begin
                bits = cols[39 - 8 * c -: 8];
                for (int r = 0; r < GLYPH_ROWS; r++)
                begin
                    px = ox + 8'(c);
                    py = oy + 8'(r);
                    px1 = px + 8'd1;
                    py1 = py + 8'd1;
                    // 90 degree rotation, 8-bit wrap on both rows
                    a = PANEL_WIDTH - py - 8'd1;
                    b = PANEL_WIDTH - py1 - 8'd1;
                    p.ram_x = (a < b) ? a : b;
                    p.win_x_end = (a < b) ? b : a;
                    p.ram_y = (px < px1) ? px : px1;
                    p.win_y_end = (px < px1) ? px1 : px;
                    p.color = bits[r] ? fg : bg;
                    p.last = (c == GLYPH_COLS - 1) && (r == GLYPH_ROWS - 1);
                    pixels_due.push_back(p);
                end
            end
        end
    endtask

    // Request driver: stage, wait out the gap and any drain, offer until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_glyph(char_code, origin_x, origin_y, fg_color, bg_color);
                requests_taken++;
            end
            if (!(push && full))
            begin
                if (!staged && req_q.size() != 0)
                begin
                    staged_req = req_q.pop_front();
                    staged = 1'b1;
                end
                if (staged && staged_req.gap != 0)
                begin
                    staged_req.gap = staged_req.gap - 5'd1;
                    push <= 1'b0;
                end
                else if (staged && (!staged_req.drain || pixels_due.size() == 0))
                begin
                    push <= 1'b1;
                    char_code <= staged_req.code;
                    origin_x <= staged_req.ox;
                    origin_y <= staged_req.oy;
                    fg_color <= staged_req.fg;
                    bg_color <= staged_req.bg;
                    staged = 1'b0;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: compare against the oldest prediction, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pixels_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected pixel x=%h y=%h xe=%h ye=%h c=%h l=%b",
                                 $realtime, ram_x, ram_y, win_x_end, win_y_end,
                                 pixel_color, last_pixel);
                end
                else
                begin
                    pixel_t e;
                    e = pixels_due.pop_front();
                    if (ram_x !== e.ram_x || ram_y !== e.ram_y ||
                        win_x_end !== e.win_x_end || win_y_end !== e.win_y_end ||
                        pixel_color !== e.color || last_pixel !== e.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: pixel mismatch exp x=%h y=%h xe=%h ye=%h c=%h l=%b %s",
                                     $realtime, e.ram_x, e.ram_y, e.win_x_end, e.win_y_end,
                                     e.color, e.last, "");
                        if (errors <= 10)
                            $display("%0t:                got x=%h y=%h xe=%h ye=%h c=%h l=%b",
                                     $realtime, ram_x, ram_y, win_x_end, win_y_end,
                                     pixel_color, last_pixel);
                    end
                end
                pixels_seen++;
                // switch between stalling and full-rate stretches now and then
                if (pixels_seen % 80 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 19);
            end
            if (rx_wait != 0)
            begin
                rx_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= !hold_long;
            end
        end
    end

    // Long receiver hold-off while the sender keeps pushing, so the input stalls
    initial
    begin
        wait (rst_n === 1'b1);
        while (requests_taken < 30)
            @(negedge clk);
        @(posedge clk);
        hold_long <= 1'b1;
        repeat (400) @(posedge clk);
        hold_long <= 1'b0;
    end

    // Stimulus: directed corner cases, then random requests
    initial
    begin
        draw_req_t d;
        bit        burst;
        d = '0;

        // out-of-range codes on both sides of the drawable range
        d.code = 8'h00; d.ox = 8'h00; d.oy = 8'h00; d.fg = 16'hFFFF; d.bg = 16'h0000;
        req_q.push_back(d);
        d.code = 8'h1F; req_q.push_back(d);
        d.code = 8'h80; req_q.push_back(d);
        d.code = 8'hFF; req_q.push_back(d);
        // first and last drawable codes, zero origin
        d.code = CODE_FIRST; req_q.push_back(d);
        d.code = CODE_LAST; d.fg = 16'h0000; d.bg = 16'hFFFF; req_q.push_back(d);
        // backtick is the last font entry; lower case folds onto upper case
        d.code = 8'h60; d.fg = 16'hAAAA; d.bg = 16'h5555; req_q.push_back(d);
        d.code = 8'h61; d.fg = 16'h5555; d.bg = 16'hAAAA; req_q.push_back(d);
        d.code = 8'h41; req_q.push_back(d);
        d.code = 8'h7B; req_q.push_back(d);
        d.code = 8'h5F; req_q.push_back(d);
        // coordinate wrap at 255 on both axes
        d.code = 8'h57; d.ox = 8'hFF; d.oy = 8'hFF; d.fg = 16'hFFFF; d.bg = 16'h0000;
        req_q.push_back(d);
        d.code = 8'h4D; d.ox = 8'hFB; d.oy = 8'hFA; req_q.push_back(d);
        // rows crossing the rotation wrap near the panel width
        d.code = 8'h23; d.ox = 8'h10; d.oy = 8'd170; req_q.push_back(d);
        d.code = 8'h40; d.ox = 8'hFE; d.oy = 8'd174; req_q.push_back(d);
        d.code = 8'h38; d.ox = 8'h80; d.oy = 8'd175; d.fg = 16'h8001; d.bg = 16'h7FFE;
        req_q.push_back(d);
        // drawable after drain, with a gap on the sender side
        d.code = 8'h51; d.ox = 8'h7F; d.oy = 8'h80; d.gap = 5'd7; d.drain = 1'b1;
        req_q.push_back(d);
        d.gap = 5'd0; d.drain = 1'b0;
        d.code = 8'h7F; d.ox = 8'h00; d.oy = 8'hFF; req_q.push_back(d);
        d.code = 8'h7E; d.ox = 8'hFF; d.oy = 8'h00; req_q.push_back(d);

        // random part, mostly drawable codes
        burst = 1'b0;
        for (int i = 0; i < 110; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                d.code = 8'($urandom_range(32, 127));
            else
                d.code = 8'($urandom_range(0, 255));
            d.ox = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(248, 255))
                                               : 8'($urandom);
            case ($urandom_range(0, 5))
                0: d.oy = 8'($urandom_range(166, 178));
                1: d.oy = 8'($urandom_range(248, 255));
                default: d.oy = 8'($urandom);
            endcase
            d.fg = 16'($urandom);
            d.bg = 16'($urandom);
            if ($urandom_range(0, 9) == 0)
                burst = !burst;
            // back-to-back drawable requests around the receiver hold-off
            if (req_q.size() >= 28 && req_q.size() < 50)
            begin
                d.gap = 5'd0;
                d.code = 8'($urandom_range(32, 127));
            end
            else
            begin
                d.gap = burst ? 5'd0 : 5'($urandom_range(0, 19));
            end
            d.drain = (i % 37 == 36);
            req_q.push_back(d);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // End of run: all requests sent, all pixels back, then a short settle
    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        while (req_q.size() != 0 || staged || push)
            @(negedge clk);
        while (pixels_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### glyph_pixel_generator_unit.f
rtl/core/gpg_pkg.sv
rtl/core/gpg_front.sv
rtl/core/gpg_queue.sv
rtl/core/gpg_back.sv
rtl/core/glyph_pixel_generator_unit.sv
rtl/core/gpg_checker.sv
sim/tb_glyph_pixel_generator_unit.sv
